FILE: hdl/mandelbrot_escape_time_pixel_top_defines.svh
// Assertion macros shared by the escape-time pixel evaluator
`ifndef MANDELBROT_ESCAPE_TIME_PIXEL_TOP_DEFINES_SVH
`define MANDELBROT_ESCAPE_TIME_PIXEL_TOP_DEFINES_SVH

// check a condition in the same cycle as its trigger
`define MEP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// check a condition in the cycle after its trigger
`define MEP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: hdl/mep_pkg.sv
// Shared constants, types and helper functions for the escape-time pixel evaluator
package mep_pkg;

  localparam int COL_W   = 9;
  localparam int ROW_W   = 8;
  localparam int COLOR_W = 7;
  localparam int SPAN_W  = 47;
  localparam int FIX_W   = 48;
  localparam int FRAC_W  = 40;
  localparam int HALF_W  = FIX_W / 2;
  localparam int MID_W   = 2 * HALF_W + 1;
  localparam int PROD_W  = 2 * FIX_W;
  localparam int Q_W     = PROD_W - FRAC_W;
  localparam int ACC_W   = Q_W + 2;

  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 24;
  localparam int CFG_DATA_W = 64;
  localparam int ADDR_W     = 5;
  localparam int ADDR_LSB   = 3;

  localparam int COL_SHIFT   = 6;
  localparam int COL_DIV     = 5;
  localparam int ROW_SHIFT   = 3;
  localparam int ROW_DIV     = 25;
  localparam int YSPAN_MUL   = 4;
  localparam int YSPAN_DIV   = 5;
  localparam int SCREEN_COLS = COL_DIV << COL_SHIFT;
  localparam int SCREEN_ROWS = ROW_DIV << ROW_SHIFT;
  localparam int ITER_LIMIT  = 100;
  localparam int ITER_W      = $clog2(ITER_LIMIT + 1);

  localparam int ESCAPE_INT = 25;
  localparam int COLOR_BASE = 32;
  localparam int COLOR_SPAN = 64;

  localparam int ROWS_BITS = $clog2(SCREEN_ROWS + 1);
  localparam int ROWF_W    = ((ROWS_BITS > ROW_W) ? ROWS_BITS : ROW_W) + 1;
  localparam int YP_W      = ROWF_W + SPAN_W + 1;
  localparam int XP_W      = COL_W + SPAN_W;
  localparam int YQ_W      = FIX_W + 1;

  localparam int DIV_W     = 56;
  localparam int DIV_CHUNK = 8;
  localparam int DIV_STEPS = DIV_W / DIV_CHUNK;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);
  localparam int DIV_MAX   = (ROW_DIV > COL_DIV) ?
                             ((ROW_DIV > YSPAN_DIV) ? ROW_DIV : YSPAN_DIV) :
                             ((COL_DIV > YSPAN_DIV) ? COL_DIV : YSPAN_DIV);
  localparam int DIVR_W    = $clog2(DIV_MAX + 1);

  localparam logic [Q_W:0] ESCAPE_MAG = (Q_W + 1)'(ESCAPE_INT) << FRAC_W;

  localparam logic [SPAN_W-1:0]       SPAN_RST = 47'd3848290697216;
  localparam logic signed [FIX_W-1:0] CX_RST   = -48'sd659706976666;
  localparam logic signed [FIX_W-1:0] CY_RST   = 48'sd0;

  localparam logic [1:0] REG_SPAN_X   = 2'd0;
  localparam logic [1:0] REG_CENTER_X = 2'd1;
  localparam logic [1:0] REG_CENTER_Y = 2'd2;

  localparam logic [1:0] DOP_YSPAN = 2'd0;
  localparam logic [1:0] DOP_XOFS  = 2'd1;
  localparam logic [1:0] DOP_YOFS  = 2'd2;

  typedef struct packed {
    logic       accept;
    logic       div_start;
    logic [1:0] div_op;
    logic       load_c;
    logic       mul;
    logic       sum;
    logic       upd;
    logic       out_load;
  } mep_cmd_t;

  typedef struct packed {
    logic div_busy;
    logic stop;
  } mep_sts_t;

  typedef logic [COLOR_W-1:0] color_tab_t [ITER_LIMIT + 1];

  function automatic color_tab_t build_color_tab();
    color_tab_t tab;
    for (int i = 0; i <= ITER_LIMIT; i++) begin
      tab[i] = (i >= ITER_LIMIT - 1) ? '0 :
               COLOR_W'(COLOR_BASE + (i * COLOR_SPAN) / (ITER_LIMIT - 1));
    end
    return tab;
  endfunction

  localparam color_tab_t COLOR_TAB = build_color_tab();

  function automatic logic signed [FIX_W-1:0] sat_fix(input logic signed [ACC_W-1:0] x);
    logic signed [FIX_W-1:0] r;
    if ((&x[ACC_W-1:FIX_W-1]) || !(|x[ACC_W-1:FIX_W-1])) begin
      r = x[FIX_W-1:0];
    end else if (x[ACC_W-1]) begin
      r = {1'b1, {(FIX_W-1){1'b0}}};
    end else begin
      r = {1'b0, {(FIX_W-1){1'b1}}};
    end
    return r;
  endfunction

  function automatic logic [PROD_W-1:0] prod_join(input logic [FIX_W-1:0] ll,
                                                  input logic [MID_W-1:0] mid,
                                                  input logic [FIX_W-1:0] hh);
    return {hh, {FIX_W{1'b0}}} + (PROD_W'(mid) << HALF_W) + PROD_W'(ll);
  endfunction

endpackage

FILE: hdl/mep_ctrl.sv
// Sequencer for setup divisions, the iteration loop and the output register
`include "mandelbrot_escape_time_pixel_top_defines.svh"

module mep_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  output logic              out_tvalid,
  input  logic              out_tready,
  input  mep_pkg::mep_sts_t sts_i,
  output mep_pkg::mep_cmd_t cmd_o
);
  import mep_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_DIVY = 4'd1;
  localparam logic [3:0] S_DIVX = 4'd2;
  localparam logic [3:0] S_DIVC = 4'd3;
  localparam logic [3:0] S_MUL  = 4'd4;
  localparam logic [3:0] S_SUM  = 4'd5;
  localparam logic [3:0] S_UPD  = 4'd6;
  localparam logic [3:0] S_FIN  = 4'd7;

  logic [3:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  mep_cmd_t   cmd;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.accept    = 1'b1;
          cmd.div_start = 1'b1;
          cmd.div_op    = DOP_YSPAN;
          state_nxt     = S_DIVY;
        end
      end
      S_DIVY: begin
        if (!sts_i.div_busy) begin
          cmd.div_start = 1'b1;
          cmd.div_op    = DOP_XOFS;
          state_nxt     = S_DIVX;
        end
      end
      S_DIVX: begin
        if (!sts_i.div_busy) begin
          cmd.div_start = 1'b1;
          cmd.div_op    = DOP_YOFS;
          state_nxt     = S_DIVC;
        end
      end
      S_DIVC: begin
        if (!sts_i.div_busy) begin
          cmd.load_c = 1'b1;
          state_nxt  = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_SUM;
      end
      S_SUM: begin
        cmd.sum   = 1'b1;
        state_nxt = S_UPD;
      end
      S_UPD: begin
        cmd.upd   = 1'b1;
        state_nxt = sts_i.stop ? S_FIN : S_MUL;
      end
      S_FIN: begin
        if (!out_valid_r || out_tready) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign cmd_o      = cmd;

  `MEP_ASSERT_NEXT(a_accept_starts, in_tvalid && in_tready, state_r == S_DIVY, "accept did not start setup")
  `MEP_ASSERT_NOW(a_out_slot_free, cmd.out_load, !out_valid_r || out_tready, "result overwrote a pending beat")
  `MEP_ASSERT_NEXT(a_fin_from_stop, state_r == S_UPD && sts_i.stop, state_r == S_FIN, "stop did not end the loop")

endmodule

FILE: hdl/mep_dp.sv
// Datapath: coordinate mapping, constant divider, complex iteration and result register
`include "mandelbrot_escape_time_pixel_top_defines.svh"

module mep_dp (
  input  logic                              clk,
  input  logic                              rst_n,
  input  mep_pkg::mep_cmd_t                 cmd_i,
  output mep_pkg::mep_sts_t                 sts_o,
  input  logic [mep_pkg::COL_W-1:0]         col_i,
  input  logic [mep_pkg::ROW_W-1:0]         row_i,
  input  logic [mep_pkg::SPAN_W-1:0]        span_i,
  input  logic signed [mep_pkg::FIX_W-1:0]  cx_i,
  input  logic signed [mep_pkg::FIX_W-1:0]  cy_i,
  output logic [mep_pkg::COL_W-1:0]         out_col_o,
  output logic [mep_pkg::ROW_W-1:0]         out_row_o,
  output logic [mep_pkg::COLOR_W-1:0]       color_o
);
  import mep_pkg::*;

  // pixel and setup values
  logic [COL_W-1:0]         col_r;
  logic [ROW_W-1:0]         row_r;
  logic [XP_W-1:0]          xprod_r;
  logic signed [YP_W-1:0]   yprod_r;
  logic [SPAN_W-1:0]        ysp_r;
  logic [FIX_W-1:0]         xq_r;
  logic signed [YQ_W-1:0]   yq_r;
  logic signed [FIX_W-1:0]  cr_r, ci_r;

  // divider
  logic                     div_busy_r;
  logic [DIV_CNT_W-1:0]     div_cnt_r;
  logic [1:0]               div_op_r;
  logic                     div_neg_r;
  logic [DIV_W-1:0]         div_num_r, div_num_nxt, div_load;
  logic [DIVR_W-1:0]        div_rem_r, div_rem_nxt, div_d;
  logic                     div_last;

  // iteration
  logic signed [FIX_W-1:0]  u_r, v_r;
  logic [ITER_W-1:0]        k_r;
  logic [FIX_W-1:0]         uu_ll_r, uu_lh_r, uu_hh_r;
  logic [FIX_W-1:0]         vv_ll_r, vv_lh_r, vv_hh_r;
  logic [FIX_W-1:0]         uv_ll_r, uv_lh_r, uv_hl_r, uv_hh_r;
  logic                     uv_neg_r;
  logic [Q_W-1:0]           uu_r, vv_r;
  logic signed [Q_W-1:0]    uv_r;

  logic [COL_W-1:0]         out_col_r;
  logic [ROW_W-1:0]         out_row_r;
  logic [COLOR_W-1:0]       color_r;

  logic signed [ROWF_W-1:0] yfac;
  logic signed [YP_W-1:0]   ym;
  logic [FIX_W-1:0]         ua, va;
  logic [PROD_W-1:0]        uu_p, vv_p, uv_p;
  logic [Q_W-1:0]           uv_q, uv_s;
  logic                     uv_rem;
  logic [Q_W:0]             mag;
  logic                     stop;
  logic signed [ACC_W-1:0]  u_acc, v_acc, cr_acc, ci_acc;

  // divider step: several restoring quotient bits per cycle
  always_comb begin
    logic [DIV_W-1:0]  num;
    logic [DIVR_W-1:0] rem;
    logic [DIVR_W:0]   t;
    logic              qb;
    num = div_num_r;
    rem = div_rem_r;
    for (int i = 0; i < DIV_CHUNK; i++) begin
      t  = {rem, num[DIV_W-1]};
      qb = (t >= (DIVR_W + 1)'(div_d));
      rem = qb ? DIVR_W'(t - (DIVR_W + 1)'(div_d)) : DIVR_W'(t);
      num = {num[DIV_W-2:0], qb};
    end
    div_num_nxt = num;
    div_rem_nxt = rem;
  end

  always_comb begin
    case (div_op_r)
      DOP_YSPAN: div_d = DIVR_W'(YSPAN_DIV);
      DOP_XOFS:  div_d = DIVR_W'(COL_DIV);
      DOP_YOFS:  div_d = DIVR_W'(ROW_DIV);
      default:   div_d = DIVR_W'(ROW_DIV);
    endcase
  end

  assign ym = yprod_r >>> ROW_SHIFT;

  always_comb begin
    case (cmd_i.div_op)
      DOP_YSPAN: div_load = DIV_W'(span_i) * DIV_W'(YSPAN_MUL);
      DOP_XOFS:  div_load = DIV_W'(xprod_r >> COL_SHIFT);
      DOP_YOFS:  div_load = ym[YP_W-1] ? DIV_W'(~ym) : DIV_W'(ym);
      default:   div_load = '0;
    endcase
  end

  assign div_last = div_busy_r && (div_cnt_r == DIV_CNT_W'(DIV_STEPS - 1));
  assign yfac     = ROWF_W'(SCREEN_ROWS) - ROWF_W'(row_r);

  // iteration arithmetic
  assign ua = u_r[FIX_W-1] ? FIX_W'(-u_r) : FIX_W'(u_r);
  assign va = v_r[FIX_W-1] ? FIX_W'(-v_r) : FIX_W'(v_r);

  assign uu_p   = prod_join(uu_ll_r, {uu_lh_r, 1'b0}, uu_hh_r);
  assign vv_p   = prod_join(vv_ll_r, {vv_lh_r, 1'b0}, vv_hh_r);
  assign uv_p   = prod_join(uv_ll_r, MID_W'(uv_lh_r) + MID_W'(uv_hl_r), uv_hh_r);
  assign uv_q   = uv_p[PROD_W-1:FRAC_W];
  assign uv_rem = |uv_p[FRAC_W-1:0];
  assign uv_s   = uv_neg_r ? (~uv_q + Q_W'(!uv_rem)) : uv_q;

  assign mag   = (Q_W + 1)'(uu_r) + (Q_W + 1)'(vv_r);
  assign stop  = (k_r == ITER_W'(ITER_LIMIT)) || (mag > ESCAPE_MAG);
  assign u_acc = ACC_W'(uu_r) - ACC_W'(vv_r) + ACC_W'(cr_r);
  assign v_acc = (ACC_W'(uv_r) << 1) + ACC_W'(ci_r);

  assign cr_acc = ACC_W'(cx_i) - ACC_W'(span_i >> 1) + ACC_W'(xq_r);
  assign ci_acc = ACC_W'(cy_i) - ACC_W'(ysp_r >> 1) + ACC_W'(yq_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_busy_r <= 1'b0;
      div_cnt_r  <= '0;
      k_r        <= '0;
    end else begin
      if (cmd_i.div_start) begin
        div_busy_r <= 1'b1;
        div_cnt_r  <= '0;
      end else if (div_busy_r) begin
        div_cnt_r <= div_cnt_r + 1'b1;
        if (div_last) begin
          div_busy_r <= 1'b0;
        end
      end
      if (cmd_i.load_c) begin
        k_r <= '0;
      end else if (cmd_i.upd && !stop) begin
        k_r <= k_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    yprod_r <= YP_W'(yfac) * YP_W'($signed({1'b0, ysp_r}));
    if (cmd_i.accept) begin
      col_r   <= col_i;
      row_r   <= row_i;
      xprod_r <= XP_W'(col_i) * XP_W'(span_i);
    end
    if (cmd_i.div_start) begin
      div_op_r  <= cmd_i.div_op;
      div_neg_r <= ym[YP_W-1];
      div_num_r <= div_load;
      div_rem_r <= '0;
    end else if (div_busy_r) begin
      div_num_r <= div_num_nxt;
      div_rem_r <= div_rem_nxt;
    end
    if (div_last) begin
      case (div_op_r)
        DOP_YSPAN: ysp_r <= div_num_nxt[SPAN_W-1:0];
        DOP_XOFS:  xq_r  <= div_num_nxt[FIX_W-1:0];
        DOP_YOFS:  yq_r  <= div_neg_r ? ~div_num_nxt[YQ_W-1:0] : div_num_nxt[YQ_W-1:0];
        default:   ysp_r <= ysp_r;
      endcase
    end
    if (cmd_i.load_c) begin
      cr_r <= sat_fix(cr_acc);
      ci_r <= sat_fix(ci_acc);
      u_r  <= '0;
      v_r  <= '0;
    end else if (cmd_i.upd && !stop) begin
      u_r <= sat_fix(u_acc);
      v_r <= sat_fix(v_acc);
    end
    if (cmd_i.mul) begin
      uu_ll_r  <= FIX_W'(ua[HALF_W-1:0]) * FIX_W'(ua[HALF_W-1:0]);
      uu_lh_r  <= FIX_W'(ua[FIX_W-1:HALF_W]) * FIX_W'(ua[HALF_W-1:0]);
      uu_hh_r  <= FIX_W'(ua[FIX_W-1:HALF_W]) * FIX_W'(ua[FIX_W-1:HALF_W]);
      vv_ll_r  <= FIX_W'(va[HALF_W-1:0]) * FIX_W'(va[HALF_W-1:0]);
      vv_lh_r  <= FIX_W'(va[FIX_W-1:HALF_W]) * FIX_W'(va[HALF_W-1:0]);
      vv_hh_r  <= FIX_W'(va[FIX_W-1:HALF_W]) * FIX_W'(va[FIX_W-1:HALF_W]);
      uv_ll_r  <= FIX_W'(ua[HALF_W-1:0]) * FIX_W'(va[HALF_W-1:0]);
      uv_lh_r  <= FIX_W'(ua[HALF_W-1:0]) * FIX_W'(va[FIX_W-1:HALF_W]);
      uv_hl_r  <= FIX_W'(ua[FIX_W-1:HALF_W]) * FIX_W'(va[HALF_W-1:0]);
      uv_hh_r  <= FIX_W'(ua[FIX_W-1:HALF_W]) * FIX_W'(va[FIX_W-1:HALF_W]);
      uv_neg_r <= u_r[FIX_W-1] ^ v_r[FIX_W-1];
    end
    if (cmd_i.sum) begin
      uu_r <= uu_p[PROD_W-1:FRAC_W];
      vv_r <= vv_p[PROD_W-1:FRAC_W];
      uv_r <= uv_s;
    end
    if (cmd_i.out_load) begin
      out_col_r <= col_r;
      out_row_r <= row_r;
      color_r   <= COLOR_TAB[k_r];
    end
  end

  assign sts_o.div_busy = div_busy_r;
  assign sts_o.stop     = stop;
  assign out_col_o      = out_col_r;
  assign out_row_o      = out_row_r;
  assign color_o        = color_r;

  `MEP_ASSERT_NOW(a_k_bound, 1'b1, k_r <= ITER_W'(ITER_LIMIT), "iteration count past limit")
  `MEP_ASSERT_NEXT(a_div_runs, cmd_i.div_start, div_busy_r, "divider did not start")
  `MEP_ASSERT_NOW(a_div_idle_start, cmd_i.div_start, !div_busy_r, "divider restarted while busy")

endmodule

FILE: hdl/mandelbrot_escape_time_pixel_top.sv
// Top level: configuration registers, controller and datapath of the escape-time evaluator
//
//   port group  direction  beat content
//   in_*        slave      pixel column and row
//   out_*       master     column, row and palette index
//   p*          APB        view span and view center registers
//
// One pixel goes from accept to result through these steps, for n = 1..100 iterations:
// accept, three constant divisions, n + 1 passes of multiply, product combine and update
// (the last pass only sees the stop), one result load.
// rst_n is synchronous, active low; it clears the sequencer and the output valid.
// A finished beat waits in the output register while the next pixel is taken;
// the next result holds in its final cycle until that beat leaves.
module mandelbrot_escape_time_pixel_top (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [mep_pkg::IN_DATA_W-1:0]     in_tdata,   // pixel_column, pixel_row
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [mep_pkg::OUT_DATA_W-1:0]    out_tdata,  // out_column, out_row, pixel_color
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [mep_pkg::ADDR_W-1:0]        paddr,
  input  logic [mep_pkg::CFG_DATA_W-1:0]    pwdata,
  output logic [mep_pkg::CFG_DATA_W-1:0]    prdata,
  output logic                              pready
);
  import mep_pkg::*;

  logic [SPAN_W-1:0]       span_r;
  logic signed [FIX_W-1:0] cx_r, cy_r;
  logic [1:0]              reg_idx;
  logic                    wr_en;
  mep_cmd_t                cmd;
  mep_sts_t                sts;
  logic [COL_W-1:0]        out_col;
  logic [ROW_W-1:0]        out_row;
  logic [COLOR_W-1:0]      color;

  assign pready  = 1'b1;
  assign reg_idx = paddr[ADDR_W-1:ADDR_LSB];
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      span_r <= SPAN_RST;
      cx_r   <= CX_RST;
      cy_r   <= CY_RST;
    end else if (wr_en) begin
      case (reg_idx)
        REG_SPAN_X:   span_r <= pwdata[SPAN_W-1:0];
        REG_CENTER_X: cx_r   <= pwdata[FIX_W-1:0];
        REG_CENTER_Y: cy_r   <= pwdata[FIX_W-1:0];
        default:      span_r <= span_r;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_SPAN_X:   prdata = CFG_DATA_W'(span_r);
      REG_CENTER_X: prdata = CFG_DATA_W'(unsigned'(cx_r));
      REG_CENTER_Y: prdata = CFG_DATA_W'(unsigned'(cy_r));
      default:      prdata = '0;
    endcase
  end

  mep_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  mep_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_i     (cmd),
    .sts_o     (sts),
    .col_i     (in_tdata[COL_W-1:0]),
    .row_i     (in_tdata[COL_W+ROW_W-1:COL_W]),
    .span_i    (span_r),
    .cx_i      (cx_r),
    .cy_i      (cy_r),
    .out_col_o (out_col),
    .out_row_o (out_row),
    .color_o   (color)
  );

  assign out_tdata = {color, out_row, out_col};

endmodule

FILE: test/escape_pixel_checker.sv
// Checker for the escape-time pixel evaluator: tracks the view registers, predicts colors, compares beats
`timescale 1ns / 100ps

module escape_pixel_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  input  logic                           in_tready,
  input  logic [mep_pkg::IN_DATA_W-1:0]  in_tdata,   // pixel_column, pixel_row
  input  logic                           out_tvalid,
  input  logic                           out_tready,
  input  logic [mep_pkg::OUT_DATA_W-1:0] out_tdata,  // out_column, out_row, pixel_color
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [mep_pkg::ADDR_W-1:0]     paddr,
  input  logic [mep_pkg::CFG_DATA_W-1:0] pwdata,
  input  logic [mep_pkg::CFG_DATA_W-1:0] prdata,
  input  logic                           pready,
  output int                             error_count,
  output int                             pending_count,
  output int                             checked_count
);
  import mep_pkg::*;

  localparam longint FIX_MAX = (longint'(1) <<< (FIX_W - 1)) - 1;
  localparam longint FIX_MIN = -(longint'(1) <<< (FIX_W - 1));

  typedef struct packed {
    logic [COL_W-1:0]   col;
    logic [ROW_W-1:0]   row;
    logic [COLOR_W-1:0] color;
  } pixel_result_t;

  pixel_result_t             expected_pixels[$];
  logic [SPAN_W-1:0]         span_q;
  logic signed [FIX_W-1:0]   center_x_q;
  logic signed [FIX_W-1:0]   center_y_q;
  int                        errors  = 0;
  int                        checked = 0;
  int                        pending = 0;

  assign error_count   = errors;
  assign pending_count = pending;
  assign checked_count = checked;

  function automatic longint clamp_fix(longint x);
    if (x > FIX_MAX) return FIX_MAX;
    if (x < FIX_MIN) return FIX_MIN;
    return x;
  endfunction

  function automatic longint mul_frac(longint a, longint b);
    logic signed [127:0] prod;
    prod = a * b;
    return longint'(prod >>> FRAC_W);
  endfunction

  function automatic logic [COLOR_W-1:0] escape_color(logic [COL_W-1:0] col,
                                                      logic [ROW_W-1:0] row,
                                                      logic [SPAN_W-1:0] span,
                                                      logic signed [FIX_W-1:0] cx,
                                                      logic signed [FIX_W-1:0] cy);
    longint unsigned s;
    longint unsigned ys;
    longint unsigned xofs;
    longint          num;
    longint          yofs;
    longint          cr;
    longint          ci;
    longint          u;
    longint          v;
    longint          uu;
    longint          vv;
    longint          uv;
    longint          mag;
    longint          limit_mag;
    int              k;
    s    = span;
    ys   = (s * YSPAN_MUL) / YSPAN_DIV;
    xofs = (s * longint'(col)) / SCREEN_COLS;
    cr   = clamp_fix(longint'(cx) - longint'(s >> 1) + longint'(xofs));
    num  = (longint'(SCREEN_ROWS) - longint'(row)) * longint'(ys);
    yofs = num / SCREEN_ROWS;
    if ((num % SCREEN_ROWS != 0) && (num < 0)) yofs = yofs - 1;
    ci   = clamp_fix(longint'(cy) - longint'(ys >> 1) + yofs);
    limit_mag = longint'(ESCAPE_INT) <<< FRAC_W;
    u   = 0;
    v   = 0;
    mag = 0;
    k   = 0;
    while (k < ITER_LIMIT && mag <= limit_mag) begin
      uu  = mul_frac(u, u);
      vv  = mul_frac(v, v);
      uv  = mul_frac(u, v);
      u   = clamp_fix(uu - vv + cr);
      v   = clamp_fix(2 * uv + ci);
      mag = mul_frac(u, u) + mul_frac(v, v);
      k++;
    end
    if (k >= ITER_LIMIT - 1) return '0;
    return COLOR_W'(COLOR_BASE + (k * COLOR_SPAN) / (ITER_LIMIT - 1));
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
    errors++;
  endtask

  always @(posedge clk) begin
    pixel_result_t seen;
    pixel_result_t want;
    if (!rst_n) begin
      span_q     = SPAN_RST;
      center_x_q = CX_RST;
      center_y_q = CY_RST;
      expected_pixels.delete();
    end else begin
      if (psel && penable && pready) begin
        if (pwrite) begin
          case (paddr[ADDR_LSB +: 2])
            REG_SPAN_X:   span_q     = pwdata[SPAN_W-1:0];
            REG_CENTER_X: center_x_q = pwdata[FIX_W-1:0];
            REG_CENTER_Y: center_y_q = pwdata[FIX_W-1:0];
            default: ;
          endcase
        end else begin
          case (paddr[ADDR_LSB +: 2])
            REG_SPAN_X:
              if (prdata[SPAN_W-1:0] != span_q)
                report_mismatch("view_span_x read", prdata[SPAN_W-1:0], span_q);
            REG_CENTER_X:
              if (prdata[FIX_W-1:0] != center_x_q)
                report_mismatch("view_center_x read", $signed(prdata[FIX_W-1:0]), center_x_q);
            REG_CENTER_Y:
              if (prdata[FIX_W-1:0] != center_y_q)
                report_mismatch("view_center_y read", $signed(prdata[FIX_W-1:0]), center_y_q);
            default: ;
          endcase
        end
      end
      if (in_tvalid && in_tready) begin
        want.col   = in_tdata[COL_W-1:0];
        want.row   = in_tdata[COL_W +: ROW_W];
        want.color = escape_color(want.col, want.row, span_q, center_x_q, center_y_q);
        expected_pixels.push_back(want);
      end
      if (out_tvalid && out_tready) begin
        seen.col   = out_tdata[COL_W-1:0];
        seen.row   = out_tdata[COL_W +: ROW_W];
        seen.color = out_tdata[COL_W + ROW_W +: COLOR_W];
        if (expected_pixels.size() == 0) begin
          report_mismatch("results pending at an output beat", 0, 1);
        end else begin
          want = expected_pixels.pop_front();
          checked++;
          if (seen.col != want.col) report_mismatch("out_column", seen.col, want.col);
          if (seen.row != want.row) report_mismatch("out_row", seen.row, want.row);
          if (seen.color != want.color) report_mismatch("pixel_color", seen.color, want.color);
        end
      end
    end
    pending = expected_pixels.size();
  end

endmodule

FILE: test/testbench.sv
// Testbench top: clock, reset, view setup over APB, pixel stimulus and verdict
`timescale 1ns / 100ps

module testbench;
  import mep_pkg::*;

  localparam int           CYCLE_LIMIT  = 2_000_000;
  localparam int           DRAIN_CYCLES = 400;
  localparam int           RANDOM_VIEWS = 8;
  localparam int           VIEW_ITEMS   = 50;
  localparam logic [1:0]   REG_UNUSED   = 2'd3;
  localparam real          ONE_FIX      = 1099511627776.0;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_RANDOM,
    STALL_SPARSE,
    STALL_PERIODIC
  } stall_mode_t;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;   // pixel_column, pixel_row
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;         // out_column, out_row, pixel_color
  logic                  psel       = 1'b0;
  logic                  penable    = 1'b0;
  logic                  pwrite     = 1'b0;
  logic [ADDR_W-1:0]     paddr      = '0;
  logic [CFG_DATA_W-1:0] pwdata     = '0;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  int          error_count;
  int          pending_count;
  int          checked_count;
  int          cycles        = 0;
  int          pixels_sent   = 0;
  int          views_applied = 0;
  int          burst_left    = 0;
  stall_mode_t stall_mode    = STALL_NONE;
  int          stall_timer   = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  mandelbrot_escape_time_pixel_top u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  escape_pixel_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .error_count   (error_count),
    .pending_count (pending_count),
    .checked_count (checked_count)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding", cycles, pending_count);
      $display("Some tests failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (stall_timer == 0) begin
      stall_mode  <= stall_mode_t'($urandom_range(0, 3));
      stall_timer <= $urandom_range(50, 600);
    end else begin
      stall_timer <= stall_timer - 1;
    end
    case (stall_mode)
      STALL_NONE:   out_tready <= 1'b1;
      STALL_RANDOM: out_tready <= ($urandom_range(0, 1) == 1);
      STALL_SPARSE: out_tready <= ($urandom_range(0, 7) == 0);
      default:      out_tready <= (stall_timer[3:0] >= 4'd10);
    endcase
  end

  function automatic logic [63:0] to_fix(real r);
    return 64'(longint'(r * ONE_FIX));
  endfunction

  task automatic apb_access(logic [1:0] idx, logic is_write, logic [63:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= is_write;
    paddr   <= ADDR_W'(idx) << ADDR_LSB;
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_view(logic [63:0] span, logic [63:0] cx, logic [63:0] cy);
    apb_access(REG_SPAN_X, 1'b1, span);
    apb_access(REG_CENTER_X, 1'b1, cx);
    apb_access(REG_CENTER_Y, 1'b1, cy);
    apb_access(REG_SPAN_X, 1'b0, '0);
    apb_access(REG_CENTER_X, 1'b0, '0);
    apb_access(REG_CENTER_Y, 1'b0, '0);
    views_applied++;
  endtask

  task automatic wait_for_results();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
  endtask

  task automatic send_pixel(int col, int row);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tdata  <= IN_DATA_W'({ROW_W'(row), COL_W'(col)});
    do @(posedge clk); while (!in_tready);
    pixels_sent++;
  endtask

  task automatic send_random_pixel();
    if ($urandom_range(0, 4) == 0) send_pixel($urandom_range(0, 511), $urandom_range(0, 255));
    else send_pixel($urandom_range(0, SCREEN_COLS - 1), $urandom_range(0, SCREEN_ROWS - 1));
  endtask

  initial begin
    logic [63:0] span;
    logic [63:0] cx;
    logic [63:0] cy;
    int          e;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset view: screen corners, center and off-screen pixels
    apb_access(REG_SPAN_X, 1'b0, '0);
    apb_access(REG_CENTER_X, 1'b0, '0);
    apb_access(REG_CENTER_Y, 1'b0, '0);
    send_pixel(0, 0);
    send_pixel(SCREEN_COLS - 1, SCREEN_ROWS - 1);
    send_pixel(SCREEN_COLS / 2, SCREEN_ROWS / 2);
    send_pixel(511, 255);
    send_pixel(0, 255);
    send_pixel(511, 0);
    send_pixel(400, 230);
    wait_for_results();

    // zero span inside the set, then zero span far outside
    set_view('0, '0, '0);
    send_pixel(0, 0);
    send_pixel(SCREEN_COLS - 1, SCREEN_ROWS - 1);
    wait_for_results();
    set_view('0, to_fix(2.0), '0);
    send_pixel(17, 33);
    send_pixel(511, 255);
    wait_for_results();

    // widest span, centers at the rails, junk above the register width
    set_view('1, 64'hFFFF_7FFF_FFFF_FFFF, 64'hABCD_8000_0000_0000);
    send_pixel(0, 0);
    send_pixel(511, 255);
    send_pixel(SCREEN_COLS - 1, 0);
    send_pixel(0, SCREEN_ROWS - 1);
    wait_for_results();

    // close zoom on the boundary; a write to the unused slot must be dropped
    set_view(to_fix(0.02), to_fix(-0.745), to_fix(0.1));
    apb_access(REG_UNUSED, 1'b1, '1);
    apb_access(REG_SPAN_X, 1'b0, '0);
    apb_access(REG_CENTER_X, 1'b0, '0);
    apb_access(REG_CENTER_Y, 1'b0, '0);
    repeat (6) send_pixel($urandom_range(0, SCREEN_COLS - 1), $urandom_range(0, SCREEN_ROWS - 1));
    wait_for_results();

    for (int p = 0; p < RANDOM_VIEWS; p++) begin
      case ($urandom_range(0, 3))
        0, 1: begin
          e    = $urandom_range(24, 43);
          span = (64'(1) << e) | ({$urandom, $urandom} & ((64'(1) << e) - 1));
          cx   = to_fix(-2.0 + 2.5 * $urandom_range(0, 1000) / 1000.0);
          cy   = to_fix(-1.2 + 2.4 * $urandom_range(0, 1000) / 1000.0);
        end
        2: begin
          span = {$urandom, $urandom};
          cx   = {$urandom, $urandom};
          cy   = {$urandom, $urandom};
        end
        default: begin
          span = {$urandom, $urandom};
          cx   = to_fix(-2.0 + 2.5 * $urandom_range(0, 1000) / 1000.0);
          cy   = to_fix(-1.2 + 2.4 * $urandom_range(0, 1000) / 1000.0);
        end
      endcase
      set_view(span, cx, cy);
      repeat (VIEW_ITEMS) send_random_pixel();
      wait_for_results();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Evaluated %0d pixels under %0d view settings plus the reset view;", pixels_sent,
             views_applied);
    $display("%0d result beats compared, %0d mismatches", checked_count, error_count);
    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
